>>> src/lpfs_pkg.sv
// Shared types, constants and helpers for the LED PWM frame serializer.
`timescale 1ns / 1ps
package lpfs_pkg;

   localparam int MAX_CHIPS         = 4;
   localparam int CHANNELS_PER_CHIP = 12;
   localparam int STORE_DEPTH       = MAX_CHIPS * CHANNELS_PER_CHIP;
   localparam int ADDR_W            = $clog2(STORE_DEPTH);
   localparam int CHIP_W            = (MAX_CHIPS > 1) ? $clog2(MAX_CHIPS) : 1;
   localparam int WORDS_PER_CHIP    = 2 + CHANNELS_PER_CHIP;
   localparam int LAST_WORD         = WORDS_PER_CHIP - 1;
   localparam int WORD_IDX_W        = $clog2(WORDS_PER_CHIP);
   localparam int NUM_CHIPS_W       = 3;
   localparam int DUTY_W            = 16;
   localparam int CHAN_W            = 6;

   localparam logic [NUM_CHIPS_W-1:0] NUM_CHIPS_RESET = 3'd1;

   // command queue between front and back, output queue of the back
   localparam int CMDQ_DEPTH = 2;
   localparam int OUT_DEPTH  = 4;

   // func codes
   localparam logic FUNC_SET  = 1'b0;
   localparam logic FUNC_XFER = 1'b1;

   // write command fields: magic, control bits, three brightness fields
   localparam logic [5:0] CMD_MAGIC  = 6'h25;
   localparam logic [4:0] CMD_CTRL   = 5'h16;
   localparam logic [6:0] CMD_BRIGHT = 7'h7F;

   typedef struct packed {
      logic              func;
      logic [CHAN_W-1:0] chan;
      logic [DUTY_W-1:0] pwm;
   } req_type;

   typedef struct packed {
      logic              ok;
      logic              is_frame_word;
      logic [DUTY_W-1:0] frame_word;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic              func;
      logic [CHAN_W-1:0] chan;
      logic [DUTY_W-1:0] pwm;
      logic              inrange;
      logic [CHIP_W-1:0] last_chip;
   } cmd_type;

   function automatic logic [31:0] write_command();
      return {CMD_MAGIC, CMD_CTRL, CMD_BRIGHT, CMD_BRIGHT, CMD_BRIGHT};
   endfunction

endpackage

>>> src/lpfs_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module lpfs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 48
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/lpfs_front.sv
// Front end: config register, item classification and the command queue.
`timescale 1ns / 1ps
module lpfs_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   output logic                                full,
   input  lpfs_pkg::req_type                   req_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lpfs_pkg::NUM_CHIPS_W-1:0]    csr_data,
   output logic                                cmd_valid,
   output lpfs_pkg::cmd_type                   cmd_data,
   input  logic                                cmd_pop
);
   import lpfs_pkg::*;

   localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
   localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

   logic [NUM_CHIPS_W-1:0] num_chips_ff, num_chips_in;
   logic [NUM_CHIPS_W-1:0] chips;
   logic [CHAN_W-1:0]      chan_limit;
   cmd_type                cmd_new;
   logic                   accept;

   cmd_type                q_ff [CMDQ_DEPTH];
   logic [PTR_W-1:0]       wptr_ff, wptr_in;
   logic [PTR_W-1:0]       rptr_ff, rptr_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;

   assign csr_ready = 1'b1;

   // zero acts as one chip, anything above the maximum as the maximum
   always_comb begin
      chips = num_chips_ff;
      if (num_chips_ff == '0) begin
         chips = NUM_CHIPS_W'(1);
      end else if (num_chips_ff > NUM_CHIPS_W'(MAX_CHIPS)) begin
         chips = NUM_CHIPS_W'(MAX_CHIPS);
      end
   end

   assign chan_limit = CHAN_W'(chips) * CHAN_W'(CHANNELS_PER_CHIP);

   always_comb begin
      cmd_new.func      = req_data.func;
      cmd_new.chan      = req_data.chan;
      cmd_new.pwm       = req_data.pwm;
      cmd_new.inrange   = (req_data.chan < chan_limit);
      cmd_new.last_chip = CHIP_W'(chips - NUM_CHIPS_W'(1));
   end

   assign full      = (cnt_ff == CNT_W'(CMDQ_DEPTH));
   assign accept    = push && !full;
   assign cmd_valid = (cnt_ff != '0);
   assign cmd_data  = q_ff[rptr_ff];

   always_comb begin
      num_chips_in = (csr_valid && csr_ready) ? csr_data : num_chips_ff;
      wptr_in      = accept ? PTR_W'(wptr_ff + PTR_W'(1)) : wptr_ff;
      rptr_in      = cmd_pop ? PTR_W'(rptr_ff + PTR_W'(1)) : rptr_ff;
      cnt_in       = cnt_ff + CNT_W'(accept) - CNT_W'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_chips_ff <= NUM_CHIPS_RESET;
         wptr_ff      <= '0;
         rptr_ff      <= '0;
         cnt_ff       <= '0;
      end else begin
         num_chips_ff <= num_chips_in;
         wptr_ff      <= wptr_in;
         rptr_ff      <= rptr_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         q_ff[wptr_ff] <= cmd_new;
      end
   end

endmodule

>>> src/lpfs_back.sv
// Back end: duty store, set read-compare-write, frame sequencer and result queue.
`timescale 1ns / 1ps
module lpfs_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cmd_valid,
   input  lpfs_pkg::cmd_type    cmd_data,
   output logic                 cmd_pop,
   output logic                 empty,
   input  logic                 pop,
   output lpfs_pkg::rsp_type    rsp_data
);
   import lpfs_pkg::*;

   localparam int OPTR_W = $clog2(OUT_DEPTH);
   localparam int OCNT_W = $clog2(OUT_DEPTH + 1) + 1;

   typedef enum logic {ST_IDLE, ST_XFER} state_type;
   typedef enum logic [1:0] {SEL_CMD_HI, SEL_CMD_LO, SEL_DUTY} sel_type;

   localparam logic [31:0] CMD_WORD = write_command();

   state_type               state_ff, state_in;
   logic [CHIP_W-1:0]       chip_ff, chip_in;
   logic [WORD_IDX_W-1:0]   word_ff, word_in;
   logic [CHIP_W-1:0]       last_chip_ff, last_chip_in;

   // issue stage
   logic                    s1_valid_ff, s1_valid_in;
   logic                    s1_is_set_ff, s1_is_set_in;
   logic                    s1_inrange_ff, s1_inrange_in;
   sel_type                 s1_sel_ff, s1_sel_in;
   logic [DUTY_W-1:0]       s1_pwm_ff, s1_pwm_in;
   logic [ADDR_W-1:0]       s1_addr_ff, s1_addr_in;
   logic                    s1_last_ff, s1_last_in;
   logic                    s1_hit_ff, s1_hit_in;

   logic [STORE_DEPTH-1:0]  valid_ff;

   logic                    room, can_issue, issue_set, issue_word;
   logic [ADDR_W-1:0]       chip_base, rd_addr;
   logic [DUTY_W-1:0]       rd_data, duty;
   logic                    wr_en, set_ok;
   rsp_type                 rsp_new;

   rsp_type                 out_q_ff [OUT_DEPTH];
   logic [OPTR_W-1:0]       owptr_ff, orptr_ff;
   logic [OCNT_W-1:0]       ocnt_ff, ocnt_in;
   logic                    out_push, out_pop;

   // credit: results already queued plus the one in flight
   assign room      = (ocnt_ff + OCNT_W'(s1_valid_ff)) < OCNT_W'(OUT_DEPTH);
   // a set writes the store in the cycle after its read; hold issue until then
   assign can_issue = room && !(s1_valid_ff && s1_is_set_ff);
   assign cmd_pop   = (state_ff == ST_IDLE) && cmd_valid && can_issue;
   assign issue_set  = cmd_pop && (cmd_data.func == FUNC_SET);
   assign issue_word = (state_ff == ST_XFER) && can_issue;

   assign chip_base = ADDR_W'(chip_ff) * ADDR_W'(CHANNELS_PER_CHIP);

   always_comb begin
      rd_addr = '0;
      if (issue_set) begin
         rd_addr = cmd_data.inrange ? ADDR_W'(cmd_data.chan) : '0;
      end else if (word_ff >= WORD_IDX_W'(2)) begin
         // words 2..13 carry channels 11 down to 0
         rd_addr = chip_base + ADDR_W'(WORD_IDX_W'(LAST_WORD) - word_ff);
      end
   end

   always_comb begin
      state_in      = state_ff;
      chip_in       = chip_ff;
      word_in       = word_ff;
      last_chip_in  = last_chip_ff;
      s1_valid_in   = issue_set || issue_word;
      s1_is_set_in  = issue_set;
      s1_inrange_in = cmd_data.inrange;
      s1_pwm_in     = cmd_data.pwm;
      s1_addr_in    = rd_addr;
      s1_hit_in     = valid_ff[rd_addr];
      s1_last_in    = 1'b1;
      s1_sel_in     = SEL_DUTY;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_pop && (cmd_data.func == FUNC_XFER)) begin
               state_in     = ST_XFER;
               chip_in      = '0;
               word_in      = '0;
               last_chip_in = cmd_data.last_chip;
            end
         end
         ST_XFER: begin
            if (word_ff == '0) begin
               s1_sel_in = SEL_CMD_HI;
            end else if (word_ff == WORD_IDX_W'(1)) begin
               s1_sel_in = SEL_CMD_LO;
            end
            s1_last_in = (chip_ff == last_chip_ff) && (word_ff == WORD_IDX_W'(LAST_WORD));
            if (issue_word) begin
               if (word_ff == WORD_IDX_W'(LAST_WORD)) begin
                  word_in = '0;
                  chip_in = CHIP_W'(chip_ff + CHIP_W'(1));
                  if (chip_ff == last_chip_ff) begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  word_in = WORD_IDX_W'(word_ff + WORD_IDX_W'(1));
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         chip_ff      <= '0;
         word_ff      <= '0;
         last_chip_ff <= '0;
         s1_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chip_ff      <= chip_in;
         word_ff      <= word_in;
         last_chip_ff <= last_chip_in;
         s1_valid_ff  <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_in) begin
         s1_is_set_ff  <= s1_is_set_in;
         s1_inrange_ff <= s1_inrange_in;
         s1_sel_ff     <= s1_sel_in;
         s1_pwm_ff     <= s1_pwm_in;
         s1_addr_ff    <= s1_addr_in;
         s1_last_ff    <= s1_last_in;
         s1_hit_ff     <= s1_hit_in;
      end
   end

   lpfs_ram #(
      .WIDTH (DUTY_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_addr_ff),
      .wr_data (s1_pwm_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // never-written entries read as zero
   assign duty   = s1_hit_ff ? rd_data : '0;
   assign set_ok = s1_is_set_ff && s1_inrange_ff && (duty != s1_pwm_ff);
   assign wr_en  = s1_valid_ff && set_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[s1_addr_ff] <= 1'b1;
      end
   end

   always_comb begin
      rsp_new.ok            = set_ok;
      rsp_new.is_frame_word = !s1_is_set_ff;
      rsp_new.last          = s1_last_ff;
      case (s1_sel_ff)
         SEL_CMD_HI: rsp_new.frame_word = CMD_WORD[31:16];
         SEL_CMD_LO: rsp_new.frame_word = CMD_WORD[15:0];
         default:    rsp_new.frame_word = s1_is_set_ff ? '0 : duty;
      endcase
   end

   // result queue
   assign out_push = s1_valid_ff;
   assign empty    = (ocnt_ff == '0);
   assign out_pop  = pop && !empty;
   assign rsp_data = out_q_ff[orptr_ff];
   assign ocnt_in  = ocnt_ff + OCNT_W'(out_push) - OCNT_W'(out_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         owptr_ff <= '0;
         orptr_ff <= '0;
         ocnt_ff  <= '0;
      end else begin
         if (out_push) begin
            owptr_ff <= OPTR_W'(owptr_ff + OPTR_W'(1));
         end
         if (out_pop) begin
            orptr_ff <= OPTR_W'(orptr_ff + OPTR_W'(1));
         end
         ocnt_ff <= ocnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_push) begin
         out_q_ff[owptr_ff] <= rsp_new;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      out_push |-> ocnt_ff < OCNT_W'(OUT_DEPTH))
      else $error("result queue overflow");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      ocnt_ff <= OCNT_W'(OUT_DEPTH))
      else $error("result queue count out of range");

   a_write_from_set: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> s1_is_set_ff && s1_inrange_ff)
      else $error("store written by a non-set word");

   a_set_hazard: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_is_set_ff) |-> !(issue_set || issue_word))
      else $error("read issued before pending store write");

   a_word_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_XFER) |-> word_ff <= WORD_IDX_W'(LAST_WORD))
      else $error("frame word index out of range");

endmodule

>>> src/led_pwm_frame_serializer_unit.sv
// Top level of the LED PWM frame serializer.
`timescale 1ns / 1ps
// Usage:
//   Request side is a queue write port: drive req_data and push; a word is
//   taken at a clock edge with push high and full low. func 0 sets one duty
//   channel, func 1 sends the whole frame for the chips in use.
//   Result side is a queue read port: while empty is low rsp_data holds the
//   oldest result; it is taken at an edge with pop high.
//   csr_data is the chip count, written when valid and ready are high; ready
//   is always high. Write it only while the block is idle.
// Timing:
//   A set gives one result; the back end handles it as a store read, then a
//   compare and write.
//   A transfer gives 14 words per chip, one per cycle while the result
//   queue has room; the frame sequencer emits one store read per cycle
//   while the result queue has room.
//   A two-word command queue decouples intake from the back end, so new
//   requests are taken while results wait.
// Reset: the duty store reads as all zero, the chip count is 1, queues empty.
// If the receiver stops popping, the four-word result queue fills, the back
//   end stalls, then the command queue fills and full rises. Nothing is lost.
module led_pwm_frame_serializer_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   output logic                              full,
   input  lpfs_pkg::req_type                 req_data,
   output logic                              empty,
   input  logic                              pop,
   output lpfs_pkg::rsp_type                 rsp_data,
   input  logic                              valid,
   output logic                              ready,
   input  logic [lpfs_pkg::NUM_CHIPS_W-1:0]  csr_data
);
   import lpfs_pkg::*;

   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd_data;

   lpfs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .csr_valid (valid),
      .csr_ready (ready),
      .csr_data  (csr_data),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_pop   (cmd_pop)
   );

   lpfs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_pop   (cmd_pop),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data)
   );

endmodule

>>> sim/lpfs_frame_checker.sv
// Checker for the LED PWM frame serializer: watches all channels, predicts and compares.
`timescale 1ns / 1ps
module lpfs_frame_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   input  logic                             full,
   input  lpfs_pkg::req_type                req_data,
   input  logic                             empty,
   input  logic                             pop,
   input  lpfs_pkg::rsp_type                rsp_data,
   input  logic                             valid,
   input  logic                             ready,
   input  logic [lpfs_pkg::NUM_CHIPS_W-1:0] csr_data,
   output int                               mismatches,
   output int                               outstanding
);
   import lpfs_pkg::*;

   localparam logic [31:0] FRAME_CMD = {CMD_MAGIC, CMD_CTRL, CMD_BRIGHT, CMD_BRIGHT, CMD_BRIGHT};
   localparam int PRINT_CAP = 30;

   logic [DUTY_W-1:0]      duty_copy [STORE_DEPTH];
   logic [NUM_CHIPS_W-1:0] chip_count_reg;
   rsp_type                expected_words [$];
   int                     fail_count = 0;
   int                     word_no = 0;

   assign mismatches = fail_count;

   // register keeps raw bits; 0 behaves as one chip, above MAX_CHIPS saturates
   function automatic int active_chips(input logic [NUM_CHIPS_W-1:0] n);
      if (n == 0) return 1;
      if (n > MAX_CHIPS) return MAX_CHIPS;
      return int'(n);
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      fail_count++;
      if (fail_count <= PRINT_CAP)
         $display("%0t: result word %0d, %s: got %h, expected %h",
                  $time, word_no, what, got, want);
   endtask

   task automatic predict_request(input req_type r);
      int      chips;
      int      total;
      int      k;
      rsp_type w;
      chips = active_chips(chip_count_reg);
      if (r.func == FUNC_SET) begin
         w      = '0;
         w.last = 1'b1;
         if (int'(r.chan) < chips * CHANNELS_PER_CHIP && duty_copy[r.chan] != r.pwm) begin
            duty_copy[r.chan] = r.pwm;
            w.ok = 1'b1;
         end
         expected_words.push_back(w);
      end else begin
         total = chips * WORDS_PER_CHIP;
         k     = 0;
         for (int n = 0; n < chips; n++) begin
            for (int j = 0; j < WORDS_PER_CHIP; j++) begin
               w = '0;
               w.is_frame_word = 1'b1;
               if (j == 0)
                  w.frame_word = FRAME_CMD[31:16];
               else if (j == 1)
                  w.frame_word = FRAME_CMD[15:0];
               else  // channels go out highest first
                  w.frame_word = duty_copy[n * CHANNELS_PER_CHIP + (CHANNELS_PER_CHIP - 1 - (j - 2))];
               w.last = (k == total - 1);
               k++;
               expected_words.push_back(w);
            end
         end
      end
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (expected_words.size() == 0) begin
         report_mismatch("word with nothing expected", 32'(got), 32'd0);
      end else begin
         want = expected_words.pop_front();
         if (got.ok !== want.ok) report_mismatch("ok", 32'(got.ok), 32'(want.ok));
         if (got.is_frame_word !== want.is_frame_word)
            report_mismatch("is_frame_word", 32'(got.is_frame_word), 32'(want.is_frame_word));
         if (got.frame_word !== want.frame_word)
            report_mismatch("frame_word", 32'(got.frame_word), 32'(want.frame_word));
         if (got.last !== want.last) report_mismatch("last", 32'(got.last), 32'(want.last));
      end
      word_no++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         chip_count_reg = NUM_CHIPS_RESET;
         expected_words.delete();
         for (int i = 0; i < STORE_DEPTH; i++) duty_copy[i] = '0;
      end else begin
         if (pop && !empty) check_result(rsp_data);
         if (valid && ready) chip_count_reg = csr_data;
         if (push && !full) predict_request(req_data);
      end
      outstanding <= expected_words.size();
   end

endmodule

>>> sim/tb.sv
// Testbench top for the LED PWM frame serializer: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb;
   import lpfs_pkg::*;

   localparam int QUIET_LIMIT  = 4000;
   localparam int HOLD_CYCLES  = 300;
   localparam int PHASE_ITEMS  = 40;
   localparam int NUM_PHASES   = 10;
   localparam int TAIL_CYCLES  = 20;

   logic                   clock;
   logic                   reset;
   logic                   push;
   logic                   full;
   req_type                req_data;
   logic                   empty;
   logic                   pop;
   rsp_type                rsp_data;
   logic                   valid;
   logic                   ready;
   logic [NUM_CHIPS_W-1:0] csr_data;
   int                     mismatches;
   int                     outstanding;

   logic hold_request;
   bit   hold_done = 1'b0;
   int   burst_left = 0;
   int   chips_now = 1;
   int   quiet_cycles = 0;

   led_pwm_frame_serializer_unit DUT (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data),
      .valid    (valid),
      .ready    (ready),
      .csr_data (csr_data)
   );

   lpfs_frame_checker frame_checker (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .req_data    (req_data),
      .empty       (empty),
      .pop         (pop),
      .rsp_data    (rsp_data),
      .valid       (valid),
      .ready       (ready),
      .csr_data    (csr_data),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ends the run when nothing moves on any channel for too long
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty) || (valid && ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   function automatic req_type mk_req(input logic func, input int chan, input int pwm);
      req_type r;
      r.func = func;
      r.chan = chan[CHAN_W-1:0];
      r.pwm  = pwm[DUTY_W-1:0];
      return r;
   endfunction

   function automatic req_type random_req(input int xfer_pct);
      int chan;
      int pwm;
      int pick;
      if ($urandom_range(0, 9) == 0)
         chan = $urandom_range(0, 63);
      else
         chan = $urandom_range(0, chips_now * CHANNELS_PER_CHIP + 3);
      pick = $urandom_range(0, 9);
      // small values repeat often, so equal-value sets come up
      if (pick < 3)      pwm = $urandom_range(0, 2);
      else if (pick < 4) pwm = 16'hFFFF;
      else               pwm = $urandom();
      if ($urandom_range(0, 99) < xfer_pct) return mk_req(FUNC_XFER, chan, pwm);
      return mk_req(FUNC_SET, chan, pwm);
   endfunction

   task automatic send_item(input req_type r);
      int gap;
      push     <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (full) @(posedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 15);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic wait_drained();
      if (push) push <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic write_chips(input logic [NUM_CHIPS_W-1:0] v);
      valid    <= 1'b1;
      csr_data <= v;
      @(posedge clock);
      while (!ready) @(posedge clock);
      valid <= 1'b0;
      chips_now = (v == 0) ? 1 : ((v > MAX_CHIPS) ? MAX_CHIPS : int'(v));
   endtask

   // receiver: changing pop patterns, plus one long hold-off on request
   initial begin
      int mode;
      int span;
      pop <= 1'b0;
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(10, 60);
         for (int c = 0; c < span; c++) begin
            @(posedge clock);
            if (hold_request && !hold_done) begin
               pop <= 1'b0;
               for (int h = 0; h < HOLD_CYCLES; h++) @(posedge clock);
               hold_done = 1'b1;
            end
            case (mode)
               0: begin
                  pop <= 1'b1;
               end
               1: begin
                  pop <= $urandom_range(0, 1);
               end
               2: begin
                  pop <= ($urandom_range(0, 3) == 0);
               end
               default: begin
                  pop <= ((c % 8) < 5);
               end
            endcase
         end
      end
   end

   initial begin
      logic [NUM_CHIPS_W-1:0] phase_setting [NUM_PHASES];
      phase_setting = '{3'd4, 3'd2, 3'd3, 3'd1, 3'd0, 3'd5, 3'd6, 3'd7, 3'd4, 3'd3};
      reset        <= 1'b1;
      push         <= 1'b0;
      req_data     <= '0;
      valid        <= 1'b0;
      csr_data     <= NUM_CHIPS_RESET;
      hold_request <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // one chip after reset: equal values, range edges, then a frame
      send_item(mk_req(FUNC_SET, 0, 16'h0000));
      send_item(mk_req(FUNC_SET, 0, 16'hFFFF));
      send_item(mk_req(FUNC_SET, 0, 16'hFFFF));
      send_item(mk_req(FUNC_SET, 11, 16'h8000));
      send_item(mk_req(FUNC_SET, 12, 16'h1234));
      send_item(mk_req(FUNC_SET, 63, 16'hFFFF));
      send_item(mk_req(FUNC_XFER, 0, 0));
      wait_drained();

      write_chips(3'd4);
      send_item(mk_req(FUNC_SET, 47, 16'hFFFF));
      send_item(mk_req(FUNC_SET, 12, 16'h1234));
      send_item(mk_req(FUNC_SET, 36, 16'h0001));
      send_item(mk_req(FUNC_SET, 48, 16'hAAAA));
      send_item(mk_req(FUNC_SET, 63, 16'h5555));
      send_item(mk_req(FUNC_XFER, 63, 16'hFFFF));
      wait_drained();

      // zero chips behaves as one
      write_chips(3'd0);
      send_item(mk_req(FUNC_SET, 12, 16'h7777));
      send_item(mk_req(FUNC_XFER, 0, 0));
      wait_drained();

      // count above the maximum saturates
      write_chips(3'd7);
      send_item(mk_req(FUNC_SET, 47, 16'h0000));
      send_item(mk_req(FUNC_XFER, 0, 0));
      wait_drained();

      for (int p = 0; p < NUM_PHASES; p++) begin
         write_chips(phase_setting[p]);
         if (p == 0) hold_request <= 1'b1;
         for (int i = 0; i < PHASE_ITEMS; i++)
            send_item(random_req((p == 0) ? 60 : 12));
         wait_drained();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
